@@ rtl/core/ssbf_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ssbf_pkg
// Shared types and constants for the subset-sum exhaustive search block.
// -----------------------------------------------------------------------------
package ssbf_pkg;

   localparam int DATA_W      = 32;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [DATA_W-1:0] target;
      logic [DATA_W-1:0] value;
      logic              search;
   } cmd_type;

   typedef struct packed {
      logic              found;
      logic              has_element;
      logic [DATA_W-1:0] element_value;
      logic              run_end;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SEARCH,
      ST_EMIT,
      ST_EMPTY
   } state_type;

endpackage

@@ rtl/core/ssbf_front.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ssbf_front
// Input stage: takes items, trims them to VALUE_BITS and tags search starts.
// -----------------------------------------------------------------------------
module ssbf_front #(
   parameter int VALUE_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [63:0]       req_tdata,
   input  logic              req_tlast,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output ssbf_pkg::cmd_type cmd_data
);
   import ssbf_pkg::*;

   localparam logic [DATA_W-1:0] VMASK = DATA_W'({VALUE_BITS{1'b1}});

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_ff, hold_in;
   logic    take;

   assign req_tready = !hold_valid_ff || cmd_ready;
   assign take       = req_tvalid && req_tready;
   assign cmd_valid  = hold_valid_ff;
   assign cmd_data   = hold_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (take) begin
         hold_valid_in  = 1'b1;
         hold_in.value  = req_tdata[31:0] & VMASK;
         hold_in.target = req_tdata[63:32] & VMASK;
         hold_in.search = req_tlast;
      end else if (cmd_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

endmodule

@@ rtl/core/ssbf_queue.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ssbf_queue
// Short command FIFO between the input stage and the search engine.
// -----------------------------------------------------------------------------
module ssbf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ssbf_pkg::cmd_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output ssbf_pkg::cmd_type out_data
);
   import ssbf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               push, pop;

   assign in_ready  = fill_ff != CNT_W'(QUEUE_DEPTH);
   assign out_valid = fill_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

@@ rtl/core/ssbf_back.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ssbf_back
// Search engine: holds the set, walks candidate masks one per cycle with an
// incremental sum, then emits the chosen elements or a no-element result.
// -----------------------------------------------------------------------------
module ssbf_back #(
   parameter int MAX_ITEMS  = 20,
   parameter int VALUE_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  ssbf_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ssbf_pkg::rsp_type rsp_data
);
   import ssbf_pkg::*;

   localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   // Stepping mask m to m+1 clears the trailing ones below bit j and sets
   // bit j, so the sum moves by elem[j] - (elem[0] + ... + elem[j-1]).
   logic [VALUE_BITS-1:0] elem_ff [MAX_ITEMS];
   logic [VALUE_BITS-1:0] diff_ff [MAX_ITEMS];

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [VALUE_BITS-1:0] psum_ff, psum_in;
   logic [VALUE_BITS-1:0] target_ff, target_in;
   logic [VALUE_BITS-1:0] sum_ff, sum_in;
   logic [MAX_ITEMS-1:0]  mask_ff, mask_in;
   logic [MAX_ITEMS-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  found_ff, found_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  store_we;
   logic [IDX_W-1:0]      store_idx;
   logic [VALUE_BITS-1:0] store_value;
   logic [VALUE_BITS-1:0] store_diff;
   logic [MAX_ITEMS-1:0]  live_bits;
   logic                  mask_done;
   logic [IDX_W-1:0]      flip_idx;
   logic                  out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = state_ff == ST_LOAD;

   always_comb begin
      for (int k = 0; k < MAX_ITEMS; k++) begin
         live_bits[k] = k < int'(count_ff);
      end
      mask_done = &(mask_ff | ~live_bits);
      flip_idx  = '0;
      for (int k = MAX_ITEMS - 1; k >= 0; k--) begin
         if (!mask_ff[k]) begin
            flip_idx = IDX_W'(k);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      psum_in      = psum_ff;
      target_in    = target_ff;
      sum_in       = sum_ff;
      mask_in      = mask_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      store_we     = 1'b0;
      store_idx    = count_ff[IDX_W-1:0];
      store_value  = cmd_data.value[VALUE_BITS-1:0];
      store_diff   = cmd_data.value[VALUE_BITS-1:0] - psum_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (cmd_valid) begin
               if (count_ff < CNT_W'(MAX_ITEMS)) begin
                  store_we = 1'b1;
                  psum_in  = psum_ff + cmd_data.value[VALUE_BITS-1:0];
                  count_in = count_ff + 1'b1;
               end
               if (cmd_data.search) begin
                  target_in = cmd_data.target[VALUE_BITS-1:0];
                  sum_in    = '0;
                  mask_in   = '0;
                  state_in  = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (sum_ff == target_ff) begin
               found_in = 1'b1;
               rem_in   = mask_ff;
               idx_in   = '0;
               count_in = '0;
               psum_in  = '0;
               state_in = (mask_ff == '0) ? ST_EMPTY : ST_EMIT;
            end else if (mask_done) begin
               found_in = 1'b0;
               count_in = '0;
               psum_in  = '0;
               state_in = ST_EMPTY;
            end else begin
               mask_in = mask_ff + 1'b1;
               sum_in  = sum_ff + diff_ff[flip_idx];
            end
         end
         ST_EMIT: begin
            if (!rem_ff[0] || out_free) begin
               rem_in = rem_ff >> 1;
               idx_in = idx_ff + 1'b1;
               if (rem_ff[0]) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.found          = 1'b1;
                  rsp_in.has_element    = 1'b1;
                  rsp_in.element_value  = DATA_W'(elem_ff[idx_ff]);
                  rsp_in.run_end        = (rem_ff >> 1) == '0;
                  if ((rem_ff >> 1) == '0) begin
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.found         = found_ff;
               rsp_in.has_element   = 1'b0;
               rsp_in.element_value = '0;
               rsp_in.run_end       = 1'b1;
               state_in             = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         psum_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         psum_ff      <= psum_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      sum_ff    <= sum_in;
      mask_ff   <= mask_in;
      rem_ff    <= rem_in;
      idx_ff    <= idx_in;
      rsp_ff    <= rsp_in;
      if (store_we) begin
         elem_ff[store_idx] <= store_value;
         diff_ff[store_idx] <= store_diff;
      end
   end

endmodule

@@ rtl/core/subset_sum_brute_force.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// subset_sum_brute_force
// Exhaustive subset-sum search over a loaded set of unsigned values.
// -----------------------------------------------------------------------------
// Elements load at one item per cycle while the engine is loading; the item
// with tlast set also carries the target and starts the search. The engine
// tries one candidate mask per cycle in increasing binary order, updating the
// running sum from a per-index difference table, up to 2^n masks for n held
// elements (n <= MAX_ITEMS), and input stalls once the two-entry command queue
// and the input register fill. The answer then leaves as one result per chosen
// element, in index order; a miss or an empty-set match gives one result with
// no element. Sums wrap modulo 2^VALUE_BITS.
module subset_sum_brute_force #(
   parameter int MAX_ITEMS  = 20,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // value[31:0], target[63:32]
   input  logic        req_tlast,   // set_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // element_value[31:0]
   output logic [1:0]  rsp_tuser,   // found[0], has_element[1]
   output logic        rsp_tlast    // run_end
);
   import ssbf_pkg::*;

   logic    front_valid, front_ready;
   cmd_type front_cmd;
   logic    queue_valid, queue_ready;
   cmd_type queue_cmd;
   rsp_type rsp;

   ssbf_front #(
      .VALUE_BITS(VALUE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd_data   (front_cmd)
   );

   ssbf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_cmd),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_data  (queue_cmd)
   );

   ssbf_back #(
      .MAX_ITEMS  (MAX_ITEMS),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd_data  (queue_cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp)
   );

   assign rsp_tdata = rsp.element_value;
   assign rsp_tuser = {rsp.has_element, rsp.found};
   assign rsp_tlast = rsp.run_end;

endmodule
